@@ hw/rtl/dct_pkg.sv @@
// ----------------------------------------------------------------------------
// dct_pkg: shared types and constants for the delimiter/comment tokenizer
// Character classes, scan modes, result record and result-queue sizing.
// ----------------------------------------------------------------------------
package dct_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_COMMENT = 8'h23;  // '#'

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_WORD    = 2'd1,
    MODE_COMMENT = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    CLS_END     = 3'd0,
    CLS_COMMENT = 3'd1,
    CLS_WHITE   = 3'd2,
    CLS_DELIM   = 3'd3,
    CLS_WORD    = 3'd4
  } cls_t;

  typedef struct packed {
    logic [7:0] token_byte;
    logic       token_first;
    logic       token_last;
    logic       is_delimiter;
    logic       end_of_stream;
    logic       run_last;
  } result_t;

  // held-back word byte
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       first;
  } held_t;

  // up to two results from one input word
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } step_t;

  function automatic cls_t classify(input logic [7:0] c);
    cls_t cls;
    cls = CLS_WORD;
    case (c)
      CHAR_NUL:     cls = CLS_END;
      CHAR_COMMENT: cls = CLS_COMMENT;  // comment wins over delimiter
      8'h20, 8'h09, 8'h0A: cls = CLS_WHITE;
      8'h60, 8'h7E, 8'h21, 8'h40, 8'h24, 8'h25, 8'h5E, 8'h26,
      8'h2A, 8'h28, 8'h29, 8'h2D, 8'h3D, 8'h2B, 8'h5B, 8'h5D,
      8'h7B, 8'h7D, 8'h3B, 8'h3A, 8'h27, 8'h22, 8'h2C, 8'h2E,
      8'h3C, 8'h3E, 8'h5C, 8'h2F, 8'h3F, 8'h7C: cls = CLS_DELIM;
      default:      cls = CLS_WORD;
    endcase
    return cls;
  endfunction

endpackage

@@ hw/rtl/delimiter_comment_tokenizer.sv @@
// ----------------------------------------------------------------------------
// delimiter_comment_tokenizer: character class tokenizer, top level
// Splits a byte stream into word, delimiter and end-of-stream results.
// ----------------------------------------------------------------------------
// Each result is registered in the result queue, whose head drives the outputs.
// Throughput: one byte per cycle while the result queue has room for two
//   results; a byte yielding two results is absorbed by a four-entry result
//   queue (input stalls only when fewer than two slots are free).
// Reset (rst, synchronous, active high): scan mode idle, nothing held,
//   result queue empty.
module delimiter_comment_tokenizer (
  input  logic       clk,
  input  logic       rst,
  // byte input
  input  logic       text_valid,
  output logic       text_ready,
  input  logic [7:0] text_byte,
  // token output
  output logic       token_valid,
  input  logic       token_ready,
  output logic [7:0] token_byte,
  output logic       token_first,
  output logic       token_last,
  output logic       is_delimiter,
  output logic       end_of_stream,
  output logic       run_last
);

  // scanner state
  dct_pkg::mode_t   scan_mode;
  dct_pkg::mode_t   scan_mode_next;
  dct_pkg::held_t   held;
  dct_pkg::held_t   held_next;

  dct_pkg::step_t   step;
  dct_pkg::result_t head;
  logic             accept;
  logic             pop;
  logic             room_two;

  assign accept = text_valid & text_ready;
  assign pop    = token_valid & token_ready;

  // Room for the worst case (two results) decides readiness, so the state
  // update never has to be held back once a byte is taken.
  assign text_ready = room_two;

  dct_step u_step (
    .text_byte (text_byte),
    .mode      (scan_mode),
    .held      (held),
    .step      (step),
    .mode_next (scan_mode_next),
    .held_next (held_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode <= dct_pkg::MODE_IDLE;
      held      <= '0;
    end else if (accept) begin
      scan_mode <= scan_mode_next;
      held      <= held_next;
    end
  end

  // Results land in the queue; the queue head is the output register.
  dct_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .push_en   (accept),
    .pop       (pop),
    .head      (head),
    .not_empty (token_valid),
    .room_two  (room_two)
  );

  assign token_byte    = head.token_byte;
  assign token_first   = head.token_first;
  assign token_last    = head.token_last;
  assign is_delimiter  = head.is_delimiter;
  assign end_of_stream = head.end_of_stream;
  assign run_last      = head.run_last;

  // a word byte is held exactly while scanning inside a word
  a_held_mode: assert property (@(posedge clk) disable iff (rst)
    held.valid == (scan_mode == dct_pkg::MODE_WORD))
    else $error("held byte and scan mode disagree");

  // end of stream drains the held byte and returns to idle
  a_eos_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && text_byte == dct_pkg::CHAR_NUL) |=>
      (scan_mode == dct_pkg::MODE_IDLE && !held.valid))
    else $error("end of stream did not return to idle");

  // the end marker is always the final result of its byte
  a_eos_run_last: assert property (@(posedge clk) disable iff (rst)
    (token_valid && end_of_stream) |-> run_last)
    else $error("end marker without run_last");

endmodule

@@ hw/rtl/dct_step.sv @@
// ----------------------------------------------------------------------------
// dct_step: per-byte tokenizer step
// Classifies one byte and computes results, next scan mode and held byte.
// ----------------------------------------------------------------------------
module dct_step (
  input  logic [7:0]          text_byte,
  input  dct_pkg::mode_t      mode,
  input  dct_pkg::held_t      held,
  output dct_pkg::step_t      step,
  output dct_pkg::mode_t      mode_next,
  output dct_pkg::held_t      held_next
);

  dct_pkg::cls_t    cls;
  dct_pkg::result_t flush_rec;
  dct_pkg::result_t eos_rec;
  dct_pkg::result_t delim_rec;

  assign cls = dct_pkg::classify(text_byte);

  always_comb begin
    flush_rec               = '0;
    flush_rec.token_byte    = held.data;
    flush_rec.token_first   = held.first;
    flush_rec.token_last    = 1'b1;

    eos_rec                 = '0;
    eos_rec.end_of_stream   = 1'b1;

    delim_rec               = '0;
    delim_rec.token_byte    = text_byte;
    delim_rec.token_first   = 1'b1;
    delim_rec.token_last    = 1'b1;
    delim_rec.is_delimiter  = 1'b1;

    step      = '0;
    mode_next = mode;
    held_next = held;

    if (cls == dct_pkg::CLS_END) begin
      if (held.valid) begin
        step.count = 2'd2;
        step.res0  = flush_rec;
        step.res1  = eos_rec;
      end else begin
        step.count = 2'd1;
        step.res0  = eos_rec;
      end
      held_next = '0;
      mode_next = dct_pkg::MODE_IDLE;
    end else if (mode == dct_pkg::MODE_COMMENT) begin
      if (text_byte == dct_pkg::CHAR_NEWLINE) begin
        mode_next = dct_pkg::MODE_IDLE;
      end
    end else begin
      case (cls)
        dct_pkg::CLS_COMMENT, dct_pkg::CLS_WHITE: begin
          step.count = {1'b0, held.valid};
          step.res0  = flush_rec;
          held_next  = '0;
          mode_next  = (cls == dct_pkg::CLS_COMMENT) ? dct_pkg::MODE_COMMENT
                                                     : dct_pkg::MODE_IDLE;
        end
        dct_pkg::CLS_DELIM: begin
          if (held.valid) begin
            step.count = 2'd2;
            step.res0  = flush_rec;
            step.res1  = delim_rec;
          end else begin
            step.count = 2'd1;
            step.res0  = delim_rec;
          end
          held_next = '0;
          mode_next = dct_pkg::MODE_IDLE;
        end
        default: begin
          // word byte: release previous one as a non-final byte
          step.count           = {1'b0, held.valid};
          step.res0            = flush_rec;
          step.res0.token_last = 1'b0;
          held_next.data       = text_byte;
          held_next.valid      = 1'b1;
          held_next.first      = ~held.valid;
          mode_next            = dct_pkg::MODE_WORD;
        end
      endcase
    end

    // tag final result of this input
    if (step.count == 2'd2) begin
      step.res1.run_last = 1'b1;
    end else if (step.count == 2'd1) begin
      step.res0.run_last = 1'b1;
    end
  end

endmodule

@@ hw/rtl/dct_queue.sv @@
// ----------------------------------------------------------------------------
// dct_queue: result queue
// Small queue taking up to two results per cycle, releasing one per cycle.
// ----------------------------------------------------------------------------
module dct_queue (
  input  logic             clk,
  input  logic             rst,
  input  dct_pkg::step_t   push,
  input  logic             push_en,
  input  logic             pop,
  output dct_pkg::result_t head,
  output logic             not_empty,
  output logic             room_two
);

  dct_pkg::result_t                       mem [dct_pkg::QUEUE_DEPTH];
  logic [dct_pkg::PTR_W-1:0]              wr_ptr;
  logic [dct_pkg::PTR_W-1:0]              rd_ptr;
  logic [dct_pkg::CNT_W-1:0]              count;
  logic [1:0]                             push_n;

  assign push_n    = push_en ? push.count : 2'd0;
  assign head      = mem[rd_ptr];
  assign not_empty = (count != '0);
  assign room_two  = (count <= dct_pkg::CNT_W'(dct_pkg::QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + dct_pkg::PTR_W'(push_n);
      rd_ptr <= rd_ptr + dct_pkg::PTR_W'(pop);
      count  <= count + dct_pkg::CNT_W'(push_n) - dct_pkg::CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= push.res0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr + dct_pkg::PTR_W'(1)] <= push.res1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= dct_pkg::CNT_W'(dct_pkg::QUEUE_DEPTH))
    else $error("result queue count out of range");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from empty result queue");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push_n != 2'd0) |-> room_two)
    else $error("push without room for two results");

endmodule
